// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, off while reset is low.
`define TST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define TST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/tst_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tst_pkg
// Types and constants shared by the sighting table cells and the top level.
// ---------------------------------------------------------------------------
package tst_pkg;

    localparam int IDX_W = 8;

    localparam logic [1:0] OUT_UPDATED  = 2'd0;
    localparam logic [1:0] OUT_INSERTED = 2'd1;
    localparam logic [1:0] OUT_DROPPED  = 2'd2;

    localparam logic [3:0] HINT_NONE = 4'd0;

    typedef struct packed {
        logic                valid;
        logic                done;
        logic                ins;
        logic [IDX_W-1:0]    slot;
        logic [47:0]         addr;
        logic [3:0]          kind;
        logic [1:0]          sep;
        logic [1:0]          bat;
        logic [3:0]          hint;
        logic signed [7:0]   rssi;
        logic [31:0]         now;
        logic [1:0]          r_state;
        logic [1:0]          r_bat;
        logic [3:0]          r_hint;
        logic signed [7:0]   r_peak;
        logic [3:0]          r_kind;
        logic [31:0]         r_first;
        logic [31:0]         r_last;
    } chain_t;

endpackage

// ===== hdl/tracker_sighting_table.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tracker_sighting_table
// Insert-or-update table of tracker sightings keyed by 48-bit address,
// built as a row of entry cells that the item walks through.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// input     in         start & !busy         device_addr .. now_ms
// result    out        done (one cycle)      slot .. entries_used
//
// The item is loaded into the head register at the accepting edge, then passes
// through the register of each cell of the chain, and the result is registered
// after the last cell; done then goes high. busy is high over that span and drops
// in the cycle done is high, so the next item can be taken at the edge that ends
// it; a new item is not taken while one is in the chain. Reset clears the
// occupied count and the chain; entries hold whatever they had and are read only
// once written. done cannot be stalled.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tracker_sighting_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [47:0]        device_addr,
    input  logic [3:0]         tracker_kind,
    input  logic [1:0]         sep_state,
    input  logic [1:0]         battery_level,
    input  logic [3:0]         proto_hint,
    input  logic signed [7:0]  signal_dbm,
    input  logic [31:0]        now_ms,
    output logic               done,
    output logic [3:0]         slot,
    output logic [1:0]         outcome,
    output logic [1:0]         entry_state,
    output logic [1:0]         entry_battery,
    output logic [3:0]         entry_hint,
    output logic signed [7:0]  entry_peak_dbm,
    output logic [3:0]         entry_kind,
    output logic [31:0]        entry_first_ms,
    output logic [31:0]        entry_last_ms,
    output logic [4:0]         entries_used
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_ENTRIES);

    tst_pkg::chain_t         link [0:TABLE_ENTRIES];
    logic [TABLE_ENTRIES:0]  link_vld;

    tst_pkg::chain_t         head_reg;
    logic                    head_vld_reg;
    logic                    busy_reg;
    logic [CNT_W-1:0]        used_reg;
    logic                    done_reg;
    logic [3:0]              slot_reg;
    logic [1:0]              outcome_reg;
    logic [1:0]              state_reg;
    logic [1:0]              bat_reg;
    logic [3:0]              hint_reg;
    logic signed [7:0]       peak_reg;
    logic [3:0]              kind_reg;
    logic [31:0]             first_reg;
    logic [31:0]             last_reg;

    logic                    accept;
    tst_pkg::chain_t         tail;

    assign accept = start && !busy_reg;
    assign tail   = link[TABLE_ENTRIES];

    always_comb
    begin
        link[0]       = head_reg;
        link[0].valid = head_vld_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            tst_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .used_count (used_reg),
                .link_in    (link[gi]),
                .link_out   (link[gi+1])
            );
        end
        for (gi = 0; gi <= TABLE_ENTRIES; gi++)
        begin : g_vld
            assign link_vld[gi] = link[gi].valid;
        end
    endgenerate

    // head valid and r_* are don't-care: overridden / filled by cells
    always_ff @(posedge clk)
    begin
        head_reg.valid   <= 1'b0;
        head_reg.r_state <= '0;
        head_reg.r_bat   <= '0;
        head_reg.r_hint  <= '0;
        head_reg.r_peak  <= '0;
        head_reg.r_kind  <= '0;
        head_reg.r_first <= '0;
        head_reg.r_last  <= '0;
        if (accept)
        begin
            head_reg.done <= 1'b0;
            head_reg.ins  <= 1'b0;
            head_reg.slot <= '0;
            head_reg.addr <= device_addr;
            head_reg.kind <= tracker_kind;
            head_reg.sep  <= sep_state;
            head_reg.bat  <= battery_level;
            head_reg.hint <= proto_hint;
            head_reg.rssi <= signal_dbm;
            head_reg.now  <= now_ms;
        end
        if (tail.valid)
        begin
            if (tail.done)
            begin
                slot_reg    <= tail.slot[3:0];
                outcome_reg <= tail.ins ? tst_pkg::OUT_INSERTED : tst_pkg::OUT_UPDATED;
                state_reg   <= tail.r_state;
                bat_reg     <= tail.r_bat;
                hint_reg    <= tail.r_hint;
                peak_reg    <= tail.r_peak;
                kind_reg    <= tail.r_kind;
                first_reg   <= tail.r_first;
                last_reg    <= tail.r_last;
            end
            else
            begin
                slot_reg    <= '0;
                outcome_reg <= tst_pkg::OUT_DROPPED;
                state_reg   <= '0;
                bat_reg     <= '0;
                hint_reg    <= '0;
                peak_reg    <= '0;
                kind_reg    <= '0;
                first_reg   <= '0;
                last_reg    <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg <= 1'b0;
            busy_reg     <= 1'b0;
            used_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            head_vld_reg <= accept;
            done_reg     <= tail.valid;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (tail.valid)
            begin
                busy_reg <= 1'b0;
            end
            if (tail.valid && tail.done && tail.ins)
            begin
                used_reg <= used_reg + 1'b1;
            end
        end
    end

    assign busy           = busy_reg;
    assign done           = done_reg;
    assign slot           = slot_reg;
    assign outcome        = outcome_reg;
    assign entry_state    = state_reg;
    assign entry_battery  = bat_reg;
    assign entry_hint     = hint_reg;
    assign entry_peak_dbm = peak_reg;
    assign entry_kind     = kind_reg;
    assign entry_first_ms = first_reg;
    assign entry_last_ms  = last_reg;
    assign entries_used   = 5'(used_reg);

    `TST_ASSERT(a_one_item, clk, rst_n, ($countones(link_vld) <= 1), "more than one item in chain")
    `TST_ASSERT(a_count_max, clk, rst_n, (used_reg <= FULL), "occupied count past table size")
    `TST_ASSERT(a_drop_full, clk, rst_n, (done && outcome == tst_pkg::OUT_DROPPED) |-> (used_reg == FULL), "drop with free slots")
    `TST_ASSERT_ALWAYS(a_done_idle, clk, (done |-> !busy), "result shown while busy")

endmodule

// ===== hdl/tst_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tst_cell
// One table entry. Compares the passing item with its key, updates or fills
// itself, and hands the item on, registered, to the next cell in the next cycle.
// ---------------------------------------------------------------------------
module tst_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] used_count,
    input  tst_pkg::chain_t  link_in,
    output tst_pkg::chain_t  link_out
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [47:0]        key_reg;
    logic [3:0]         kind_reg;
    logic [1:0]         state_reg;
    logic [1:0]         bat_reg;
    logic [3:0]         hint_reg;
    logic signed [7:0]  peak_reg;
    logic [31:0]        first_reg;
    logic [31:0]        last_reg;

    logic [1:0]         state_next;
    logic [1:0]         bat_next;
    logic [3:0]         hint_next;
    logic signed [7:0]  peak_next;
    logic [31:0]        last_next;

    tst_pkg::chain_t    pay_reg;
    tst_pkg::chain_t    pay_next;
    logic               vld_reg;

    logic               searching;
    logic               hit;
    logic               fill;

    assign searching = link_in.valid && !link_in.done;
    assign hit       = searching && (MY_IDX < used_count) && (key_reg == link_in.addr);
    assign fill      = searching && (MY_IDX == used_count);

    always_comb
    begin
        state_next = link_in.sep;
        bat_next   = link_in.bat;
        last_next  = link_in.now;
        hint_next  = (link_in.hint != tst_pkg::HINT_NONE) ? link_in.hint : hint_reg;
        peak_next  = (link_in.rssi > peak_reg) ? link_in.rssi : peak_reg;

        pay_next = link_in;
        if (hit)
        begin
            pay_next.done    = 1'b1;
            pay_next.ins     = 1'b0;
            pay_next.slot    = tst_pkg::IDX_W'(IDX);
            pay_next.r_state = state_next;
            pay_next.r_bat   = bat_next;
            pay_next.r_hint  = hint_next;
            pay_next.r_peak  = peak_next;
            pay_next.r_kind  = kind_reg;
            pay_next.r_first = first_reg;
            pay_next.r_last  = last_next;
        end
        else if (fill)
        begin
            pay_next.done    = 1'b1;
            pay_next.ins     = 1'b1;
            pay_next.slot    = tst_pkg::IDX_W'(IDX);
            pay_next.r_state = link_in.sep;
            pay_next.r_bat   = link_in.bat;
            pay_next.r_hint  = link_in.hint;
            pay_next.r_peak  = link_in.rssi;
            pay_next.r_kind  = link_in.kind;
            pay_next.r_first = link_in.now;
            pay_next.r_last  = link_in.now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            state_reg <= state_next;
            bat_reg   <= bat_next;
            hint_reg  <= hint_next;
            peak_reg  <= peak_next;
            last_reg  <= last_next;
        end
        else if (fill)
        begin
            key_reg   <= link_in.addr;
            kind_reg  <= link_in.kind;
            state_reg <= link_in.sep;
            bat_reg   <= link_in.bat;
            hint_reg  <= link_in.hint;
            peak_reg  <= link_in.rssi;
            first_reg <= link_in.now;
            last_reg  <= link_in.now;
        end
        pay_reg <= pay_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= link_in.valid;
        end
    end

    always_comb
    begin
        link_out       = pay_reg;
        link_out.valid = vld_reg;
    end

endmodule
